/* rtl/mlfq_pkg.sv */
// Shared types and codes for the multilevel feedback queue scheduler.
package mlfq_pkg;

  localparam int TIME_W = 48;
  localparam int POS_W  = 64;
  localparam int THR_W  = 40;
  localparam int QNT_W  = 32;

  localparam logic [1:0] OP_CHANGE = 2'd0;
  localparam logic [1:0] OP_SELECT = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [2:0] ST_UNUSED    = 3'd0;
  localparam logic [2:0] ST_ALLOCATED = 3'd1;
  localparam logic [2:0] ST_RUNNABLE  = 3'd3;
  localparam logic [2:0] ST_RUNNING   = 3'd4;
  localparam logic [2:0] ST_LAST      = 3'd5;

  localparam logic [2:0] REG_QUANTUM0 = 3'd0;
  localparam logic [2:0] REG_QUANTUM1 = 3'd1;
  localparam logic [2:0] REG_QUANTUM2 = 3'd2;
  localparam logic [2:0] REG_AGING    = 3'd3;
  localparam logic [2:0] REG_CPT      = 3'd4;

  typedef struct packed {
    logic [2:0]        state;
    logic [1:0]        level;
    logic [TIME_W-1:0] spent;
    logic [POS_W-1:0]  pos;
    logic [TIME_W-1:0] age_start;
    logic [TIME_W-1:0] state_start;
  } entry_t;

  typedef struct packed {
    logic [7:0]  quantum0;
    logic [7:0]  quantum1;
    logic [7:0]  quantum2;
    logic [15:0] aging;
    logic [23:0] cpt;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [5:0]        slot;
    logic [2:0]        new_state;
    logic [TIME_W-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic       give_up;
    logic [1:0] chosen_level;
    logic [5:0] chosen_slot;
    logic       found;
  } result_t;

endpackage

/* rtl/mlfq_process_scheduler.sv */
// Multilevel feedback queue scheduler top level: stream ports, config, output register.
//
// Input beats on s_tvalid/s_tready carry one command each: s_tuser is the op
// (state change, select, tick), s_tdata the slot, new state and current time.
// Each command gives exactly one result beat on m_tvalid/m_tready.
// Select and tick stream the slot table through one read port, one entry a
// cycle, with the promotion written back as the entry passes. A tick whose
// quantum runs out finishes without a scan.
// One command is in flight at a time; s_tready is high only when idle.
// Results land in an output register, so a new command is accepted while a
// result waits; the sequencer holds its result if that register is full.
// Configuration writes (cfg_valid, always ready) take effect on the next
// command and are meant to be issued while the block is idle.
// After reset a clearing pass writes every slot to zero with s_tready low;
// configuration registers return to their reset values.
module mlfq_process_scheduler #(
  parameter int SLOTS  = 64,
  parameter int LEVELS = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // slot[5:0], new_state[8:6], now[56:9], zero pad
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // found[0], chosen_slot[6:1], chosen_level[8:7],
                                 // give_up[9], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import mlfq_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  result_t res;
  logic    res_valid;
  logic    res_ready;
  result_t out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quantum0 <= 8'd1;
      cfg.quantum1 <= 8'd2;
      cfg.quantum2 <= 8'd4;
      cfg.aging    <= 16'd100;
      cfg.cpt      <= 24'd1000000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_QUANTUM0: cfg.quantum0 <= cfg_data[7:0];
        REG_QUANTUM1: cfg.quantum1 <= cfg_data[7:0];
        REG_QUANTUM2: cfg.quantum2 <= cfg_data[7:0];
        REG_AGING:    cfg.aging    <= cfg_data[15:0];
        REG_CPT:      cfg.cpt      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cmd.op        = s_tuser;
  assign cmd.slot      = s_tdata[5:0];
  assign cmd.new_state = s_tdata[8:6];
  assign cmd.now       = s_tdata[56:9];

  mlfq_ctrl #(.SLOTS(SLOTS), .LEVELS(LEVELS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (s_tvalid),
    .cmd_ready (s_tready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: load when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_res <= res;
  end

  assign m_tdata = {6'd0, out_res};

endmodule

/* rtl/mlfq_table.sv */
// Task slot table: one write port, one read port with registered data.
module mlfq_table #(
  parameter int SLOTS = 64,
  parameter int SW    = 6
) (
  input  logic                  clk,
  input  logic [SW-1:0]         rd_addr,
  output mlfq_pkg::entry_t      rd_data,
  input  logic                  wr_en,
  input  logic [SW-1:0]         wr_addr,
  input  mlfq_pkg::entry_t      wr_data
);
  import mlfq_pkg::*;

  entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/mlfq_ctrl.sv */
// Sequencer: clearing pass, state change, tick and select scans over the table.
module mlfq_ctrl #(
  parameter int SLOTS  = 64,
  parameter int LEVELS = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  mlfq_pkg::cfg_t     cfg,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  mlfq_pkg::cmd_t     cmd,
  output logic               res_valid,
  input  logic               res_ready,
  output mlfq_pkg::result_t  res
);
  import mlfq_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = SW + 1;
  localparam logic [CW-1:0] LAST_CNT = CW'(SLOTS);
  localparam logic [1:0] TOP_LEVEL = 2'(LEVELS - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PREP, S_CHG, S_SC_WR, S_TK_SUM, S_TK_CHK, S_SCAN, S_DONE
  } state_t;

  state_t            state;
  cmd_t              c;
  logic [CW-1:0]     cnt;
  logic [THR_W-1:0]  thr;
  logic [QNT_W-1:0]  qnt0, qnt1, qnt2;
  logic [22:0]       half_tick;
  logic [POS_W-1:0]  pc;
  entry_t            ent;
  logic [TIME_W-1:0] dreg;
  logic [1:0]        cur_lvl;
  // scan pipeline
  logic              p1_v;
  logic [SW-1:0]     p1_idx;
  logic              c_v;
  logic [SW-1:0]     c_idx;
  logic [1:0]        c_lvl;
  logic [POS_W-1:0]  c_pos;
  logic              have;
  logic [SW-1:0]     best;
  logic [1:0]        best_lvl;
  logic [POS_W-1:0]  best_pos;
  logic              higher;
  result_t           res_next;

  logic [SW-1:0]     rd_addr;
  entry_t            rd_data;
  logic              wr_en;
  logic [SW-1:0]     wr_addr;
  entry_t            wr_data;

  logic [15:0]       slot_w;
  logic [SW-1:0]     slot_idx;
  logic              in_range;

  assign slot_w   = {10'd0, c.slot};
  assign slot_idx = slot_w[SW-1:0];
  assign in_range = 32'(c.slot) < 32'(SLOTS);

  mlfq_table #(.SLOTS(SLOTS), .SW(SW)) u_table (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // promotion of a runnable entry during a scan
  logic [TIME_W-1:0] age_diff;
  logic              scan_hit;
  logic              promote;
  logic [1:0]        prom_lvl;
  entry_t            prom_ent;

  always_comb begin
    age_diff = c.now - rd_data.age_start;
    scan_hit = p1_v && (rd_data.state == ST_RUNNABLE) &&
               ((c.op == OP_SELECT) || (p1_idx != slot_idx));
    promote  = scan_hit && (thr != '0) && (rd_data.level != 2'd0) &&
               ({8'd0, thr} <= age_diff);
    if (rd_data.level == 2'd1 || ({7'd0, thr, 1'b0} <= age_diff)) begin
      prom_lvl = 2'd0;
    end else begin
      prom_lvl = rd_data.level - 2'd1;
    end
    prom_ent           = rd_data;
    prom_ent.level     = prom_lvl;
    prom_ent.spent     = '0;
    prom_ent.pos       = pc + 64'd1;
    prom_ent.age_start = c.now;
  end

  // state change on the registered entry
  entry_t sc_ent;
  logic   sc_take;
  logic   sc_write;
  logic [TIME_W:0] sc_sum;

  always_comb begin
    sc_ent   = ent;
    sc_take  = 1'b0;
    sc_write = in_range && (c.new_state <= ST_LAST);
    sc_sum   = {1'b0, ent.spent} + {1'b0, dreg};
    if (c.new_state == ST_ALLOCATED) begin
      sc_ent.level       = 2'd0;
      sc_ent.spent       = '0;
      sc_ent.pos         = '0;
      sc_ent.age_start   = c.now;
      sc_ent.state_start = c.now;
      sc_ent.state       = c.new_state;
    end else begin
      if (ent.state == ST_RUNNING) begin
        sc_ent.spent     = sc_sum[TIME_W] ? '1 : sc_sum[TIME_W-1:0];
        sc_ent.age_start = c.now;
      end
      sc_ent.state_start = c.now;
      sc_ent.state       = c.new_state;
      if (c.new_state == ST_RUNNABLE) begin
        if (ent.state == ST_ALLOCATED) sc_ent.age_start = c.now;
        if (ent.state != ST_RUNNING) begin
          sc_ent.pos = pc + 64'd1;
          sc_take    = 1'b1;
        end
      end
    end
  end

  // tick quantum check
  logic [QNT_W-1:0]  lvl_qnt;
  logic              used_up;
  entry_t            tk_ent;

  always_comb begin
    case (ent.level)
      2'd0:    lvl_qnt = qnt0;
      2'd1:    lvl_qnt = qnt1;
      default: lvl_qnt = qnt2;
    endcase
    used_up = ({1'b0, ent.spent} + {26'd0, half_tick}) >= {17'd0, lvl_qnt};
    tk_ent  = ent;
    if (ent.level < TOP_LEVEL) tk_ent.level = ent.level + 2'd1;
    tk_ent.spent = '0;
    tk_ent.pos   = pc + 64'd1;
  end

  always_comb begin
    rd_addr = cnt[SW-1:0];
    if (state == S_PREP) rd_addr = slot_idx;
    wr_en   = 1'b0;
    wr_addr = slot_idx;
    wr_data = ent;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt[SW-1:0];
        wr_data = '0;
      end
      S_SC_WR: begin
        wr_en   = sc_write;
        wr_data = sc_ent;
      end
      S_TK_CHK: begin
        wr_en   = 1'b1;
        wr_data = used_up ? tk_ent : ent;
      end
      S_SCAN: begin
        wr_en   = promote;
        wr_addr = p1_idx;
        wr_data = prom_ent;
      end
      default: ;
    endcase
  end

  assign cmd_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      pc        <= '0;
      res_valid <= 1'b0;
      p1_v      <= 1'b0;
      c_v       <= 1'b0;
      have      <= 1'b0;
      higher    <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          cnt <= cnt + CW'(1);
          if (cnt == LAST_CNT - CW'(1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid) begin
            c     <= cmd;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          thr       <= THR_W'(cfg.aging) * THR_W'(cfg.cpt);
          qnt0      <= QNT_W'(cfg.quantum0) * QNT_W'(cfg.cpt);
          qnt1      <= QNT_W'(cfg.quantum1) * QNT_W'(cfg.cpt);
          qnt2      <= QNT_W'(cfg.quantum2) * QNT_W'(cfg.cpt);
          half_tick <= cfg.cpt[23:1];
          cnt       <= '0;
          p1_v      <= 1'b0;
          c_v       <= 1'b0;
          have      <= 1'b0;
          higher    <= 1'b0;
          res_next  <= '0;
          case (c.op)
            OP_CHANGE, OP_TICK: state <= S_CHG;
            OP_SELECT:          state <= S_SCAN;
            default:            state <= S_DONE;
          endcase
        end
        S_CHG: begin
          ent  <= rd_data;
          dreg <= c.now - rd_data.state_start;
          if (c.op == OP_CHANGE) begin
            state <= S_SC_WR;
          end else if (!in_range || rd_data.state != ST_RUNNING) begin
            state <= S_DONE;
          end else begin
            state <= S_TK_SUM;
          end
        end
        S_SC_WR: begin
          if (sc_write && sc_take) pc <= pc + 64'd1;
          state <= S_DONE;
        end
        S_TK_SUM: begin
          ent.spent       <= sc_sum[TIME_W] ? '1 : sc_sum[TIME_W-1:0];
          ent.state_start <= c.now;
          state           <= S_TK_CHK;
        end
        S_TK_CHK: begin
          cur_lvl <= ent.level;
          if (used_up) begin
            pc               <= pc + 64'd1;
            res_next.give_up <= 1'b1;
            state            <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue stage
          p1_v   <= (cnt != LAST_CNT);
          p1_idx <= cnt[SW-1:0];
          if (cnt != LAST_CNT) cnt <= cnt + CW'(1);
          // data stage: promote and hand on the candidate
          if (promote) pc <= pc + 64'd1;
          c_v   <= scan_hit;
          c_idx <= p1_idx;
          c_lvl <= promote ? prom_lvl : rd_data.level;
          c_pos <= promote ? prom_ent.pos : rd_data.pos;
          // compare stage
          if (c_v) begin
            if (!have || c_lvl < best_lvl || (c_lvl == best_lvl && c_pos < best_pos)) begin
              have     <= 1'b1;
              best     <= c_idx;
              best_lvl <= c_lvl;
              best_pos <= c_pos;
            end
            if (c_lvl < cur_lvl) higher <= 1'b1;
          end
          if (cnt == LAST_CNT && !p1_v && !c_v) begin
            if (c.op == OP_SELECT) begin
              res_next.found        <= have;
              res_next.chosen_slot  <= have ? 6'(best) : 6'd0;
              res_next.chosen_level <= have ? best_lvl : 2'd0;
            end else begin
              res_next.give_up <= higher;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            res_valid <= 1'b1;
            res       <= res_next;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
